>>> hdl/mfilt_pkg.sv
// Shared types and constants for the 3x3 median filter.
`default_nettype none

package mfilt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int WIN_EDGE   = 3;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int POS_W  = 10;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // One column of the window, top row first.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } column_t;

    // Write port of a line store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } line_wr_t;

endpackage : mfilt_pkg

`default_nettype wire

>>> hdl/mfilt_line_mem.sv
// Single-port-write, single-port-read line store with a registered read.
`default_nettype none

module mfilt_line_mem (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [mfilt_pkg::ADDR_W-1:0] rd_addr,
    output logic      [mfilt_pkg::PIX_W-1:0]  rd_data,
    input  wire mfilt_pkg::line_wr_t          wr
);

    logic [mfilt_pkg::PIX_W-1:0] mem [mfilt_pkg::MAX_WIDTH];
    logic [mfilt_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : mfilt_line_mem

`default_nettype wire

>>> hdl/mfilt_median9.sv
// Median of a 3x3 window by column sort, then max/median/min of the sorted rows.
`default_nettype none

module mfilt_median9 (
    input  wire mfilt_pkg::column_t         col_left,
    input  wire mfilt_pkg::column_t         col_center,
    input  wire mfilt_pkg::column_t         col_right,
    output logic [mfilt_pkg::PIX_W-1:0]     median
);

    typedef logic [mfilt_pkg::PIX_W-1:0] pix_t;

    function automatic pix_t min2(pix_t a, pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(pix_t a, pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    pix_t lo_l, md_l, hi_l;
    pix_t lo_c, md_c, hi_c;
    pix_t lo_r, md_r, hi_r;
    pix_t max_lo, med_md, min_hi;

    always_comb
    begin
        // Sort each column.
        lo_l = min2(min2(col_left.top, col_left.mid), col_left.bot);
        hi_l = max2(max2(col_left.top, col_left.mid), col_left.bot);
        md_l = med3(col_left.top, col_left.mid, col_left.bot);
        lo_c = min2(min2(col_center.top, col_center.mid), col_center.bot);
        hi_c = max2(max2(col_center.top, col_center.mid), col_center.bot);
        md_c = med3(col_center.top, col_center.mid, col_center.bot);
        lo_r = min2(min2(col_right.top, col_right.mid), col_right.bot);
        hi_r = max2(max2(col_right.top, col_right.mid), col_right.bot);
        md_r = med3(col_right.top, col_right.mid, col_right.bot);

        // The median of nine is the median of these three.
        max_lo = max2(max2(lo_l, lo_c), lo_r);
        med_md = med3(md_l, md_c, md_r);
        min_hi = min2(min2(hi_l, hi_c), hi_r);
        median = med3(max_lo, med_md, min_hi);
    end

endmodule : mfilt_median9

`default_nettype wire

>>> hdl/median_filter_3x3.sv
// Top level of the 3x3 median filter: counters, line stores, window and output register.
// A pixel passes the read stage (stage 1), then any result goes to the output register.
// Throughput: one pixel per cycle while out_ready is high; a stalled result holds the input.
// Items whose window would cross the top or left image edge give no result.
// Reset (rst_n low, asynchronous) clears counters, window, valid flags, and sets the geometry
// to 640 x 480. The line stores are not cleared; no clearing pass is needed.
`default_nettype none

module median_filter_3x3 (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [mfilt_pkg::PIX_W-1:0]     pixel,

    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [mfilt_pkg::PIX_W-1:0]     median,
    output logic      [mfilt_pkg::POS_W-1:0]     out_row,
    output logic      [mfilt_pkg::POS_W-1:0]     out_col,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mfilt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mfilt_pkg::DIM_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the geometry is
    // clamped to the legal range where it is used, not where it is stored.
    // ------------------------------------------------------------------
    logic [mfilt_pkg::DIM_W-1:0] line_width_reg;
    logic [mfilt_pkg::DIM_W-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= 11'd640;
            frame_height_reg <= 11'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mfilt_pkg::CFG_LINE_WIDTH:   line_width_reg   <= cfg_data;
                mfilt_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    logic [mfilt_pkg::DIM_W-1:0] width_eff;
    logic [mfilt_pkg::DIM_W-1:0] height_eff;

    always_comb
    begin
        if (line_width_reg < mfilt_pkg::DIM_W'(mfilt_pkg::WIN_EDGE))
            width_eff = mfilt_pkg::DIM_W'(mfilt_pkg::WIN_EDGE);
        else if (line_width_reg > mfilt_pkg::DIM_W'(mfilt_pkg::MAX_WIDTH))
            width_eff = mfilt_pkg::DIM_W'(mfilt_pkg::MAX_WIDTH);
        else
            width_eff = line_width_reg;

        if (frame_height_reg < mfilt_pkg::DIM_W'(mfilt_pkg::WIN_EDGE))
            height_eff = mfilt_pkg::DIM_W'(mfilt_pkg::WIN_EDGE);
        else if (frame_height_reg > mfilt_pkg::DIM_W'(mfilt_pkg::MAX_HEIGHT))
            height_eff = mfilt_pkg::DIM_W'(mfilt_pkg::MAX_HEIGHT);
        else
            height_eff = frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Handshake. Stage 1 holds the accepted pixel while the line stores
    // are read; it moves on when the output register can take its result
    // or when the item gives no result at all.
    // ------------------------------------------------------------------
    logic in_accept;
    logic s1_adv;
    logic s1_has_result;

    logic                          s1_valid_reg;
    logic [mfilt_pkg::PIX_W-1:0]   s1_pixel_reg;
    logic [mfilt_pkg::POS_W-1:0]   s1_col_reg;
    logic [mfilt_pkg::POS_W-1:0]   s1_row_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [mfilt_pkg::PIX_W-1:0]   median_reg;
    logic [mfilt_pkg::POS_W-1:0]   out_row_reg;
    logic [mfilt_pkg::POS_W-1:0]   out_col_reg;

    assign s1_has_result = (s1_row_reg >= 10'd2) && (s1_col_reg >= 10'd2);
    assign s1_adv        = s1_valid_reg && (!s1_has_result || !out_valid_reg || out_ready);
    assign in_ready      = !s1_valid_reg || s1_adv;
    assign in_accept     = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Raster position of the next pixel. A column count at or past the last
    // column wraps after the current pixel; a row count at or past the last row wraps with it.
    // ------------------------------------------------------------------
    logic [mfilt_pkg::POS_W-1:0] col_cnt_reg;
    logic [mfilt_pkg::POS_W-1:0] row_cnt_reg;
    logic [mfilt_pkg::POS_W-1:0] col_cnt_next;
    logic [mfilt_pkg::POS_W-1:0] row_cnt_next;
    logic [mfilt_pkg::DIM_W-1:0] col_plus1;
    logic [mfilt_pkg::DIM_W-1:0] row_plus1;

    always_comb
    begin
        col_plus1    = {1'b0, col_cnt_reg} + 11'd1;
        row_plus1    = {1'b0, row_cnt_reg} + 11'd1;
        col_cnt_next = col_plus1[mfilt_pkg::POS_W-1:0];
        row_cnt_next = row_cnt_reg;
        if (col_plus1 >= width_eff)
        begin
            col_cnt_next = '0;
            if (row_plus1 >= height_eff)
                row_cnt_next = '0;
            else
                row_cnt_next = row_plus1[mfilt_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (in_accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Stage 1 register: the pixel and its position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_cnt_reg;
            s1_row_reg   <= row_cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. Both are read at the accepted pixel's column; they are
    // written when that pixel leaves stage 1. The next pixel always reads
    // a different column, since a row is at least three pixels wide.
    // ------------------------------------------------------------------
    logic [mfilt_pkg::PIX_W-1:0] older_rd;
    logic [mfilt_pkg::PIX_W-1:0] newer_rd;
    mfilt_pkg::line_wr_t         older_wr;
    mfilt_pkg::line_wr_t         newer_wr;

    always_comb
    begin
        older_wr.en   = s1_adv;
        older_wr.addr = s1_col_reg;
        older_wr.data = newer_rd;
        newer_wr.en   = s1_adv;
        newer_wr.addr = s1_col_reg;
        newer_wr.data = s1_pixel_reg;
    end

    mfilt_line_mem u_older (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (col_cnt_reg),
        .rd_data (older_rd),
        .wr      (older_wr)
    );

    mfilt_line_mem u_newer (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (col_cnt_reg),
        .rd_data (newer_rd),
        .wr      (newer_wr)
    );

    // ------------------------------------------------------------------
    // Window: the two columns left of the current pixel. The current
    // column comes straight from the line stores and stage 1.
    // ------------------------------------------------------------------
    mfilt_pkg::column_t win_left_reg;
    mfilt_pkg::column_t win_center_reg;
    mfilt_pkg::column_t cur_col;
    logic [mfilt_pkg::PIX_W-1:0] median_calc;

    always_comb
    begin
        cur_col.top = older_rd;
        cur_col.mid = newer_rd;
        cur_col.bot = s1_pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= '0;
            win_center_reg <= '0;
        end
        else if (s1_adv)
        begin
            win_left_reg   <= win_center_reg;
            win_center_reg <= cur_col;
        end
    end

    mfilt_median9 u_median (
        .col_left   (win_left_reg),
        .col_center (win_center_reg),
        .col_right  (cur_col),
        .median     (median_calc)
    );

    // ------------------------------------------------------------------
    // Output register. It is loaded while the previous result is taken,
    // so results can leave one per cycle.
    // ------------------------------------------------------------------
    assign out_valid_next = (s1_adv && s1_has_result) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_has_result)
        begin
            median_reg  <= median_calc;
            out_row_reg <= s1_row_reg - 10'd2;
            out_col_reg <= s1_col_reg - 10'd2;
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An empty read stage must always be able to take an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
    else $error("input stalled with an empty read stage");

    // An accepted item reaches the read stage on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
    else $error("accepted item lost before the read stage");

    // A result never reports a window that starts past the last legal place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row <= 10'd1021) && (out_col <= 10'd1021))
    else $error("result position outside the frame");

    // A result that stalls is not overwritten by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(median) && $stable(out_col))
    else $error("stalled result was overwritten");

endmodule : median_filter_3x3

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the 3x3 median filter: random stalls, predicted medians.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that the block does not decode; writes to them must change nothing.
    localparam logic [mfilt_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [mfilt_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Quiet cycles that wait_idle requires before it returns, as margin for the pipeline.
    localparam int SETTLE_CYCLES = 6;
    // Cycles with work outstanding but no item moving on any channel before giving up.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cap on printed error lines so that a broken block cannot flood the log.
    localparam int MAX_REPORTS = 30;
    // Geometry of the directed wide and tall frames, and the number of random phases.
    localparam int WIDE_LINE     = 32;
    localparam int TALL_FRAME    = 32;
    localparam int RANDOM_PHASES = 8;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One expected median, tagged with the top-left position of its window.
    typedef struct packed {
        logic [mfilt_pkg::PIX_W-1:0] median;
        logic [mfilt_pkg::POS_W-1:0] row;
        logic [mfilt_pkg::POS_W-1:0] col;
    } median_entry_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [mfilt_pkg::PIX_W-1:0]         pixel = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [mfilt_pkg::PIX_W-1:0]         median;
    logic [mfilt_pkg::POS_W-1:0]         out_row;
    logic [mfilt_pkg::POS_W-1:0]         out_col;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [mfilt_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [mfilt_pkg::DIM_W-1:0]         cfg_data = '0;

    median_filter_3x3 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .out_row   (out_row),
        .out_col   (out_col),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns period: 6 ns high, 6 ns low.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the geometry, line stores, window and counters.
    // ------------------------------------------------------------------
    logic [mfilt_pkg::DIM_W-1:0] width_reg  = mfilt_pkg::DIM_W'(640);
    logic [mfilt_pkg::DIM_W-1:0] height_reg = mfilt_pkg::DIM_W'(480);
    logic [mfilt_pkg::PIX_W-1:0] older_line [mfilt_pkg::MAX_WIDTH] = '{default: '0};
    logic [mfilt_pkg::PIX_W-1:0] newer_line [mfilt_pkg::MAX_WIDTH] = '{default: '0};
    mfilt_pkg::column_t          win_left = '0;
    mfilt_pkg::column_t          win_mid  = '0;
    int                          col_cnt = 0;
    int                          row_cnt = 0;

    median_entry_t               pending_medians [$];
    logic [mfilt_pkg::PIX_W-1:0] pixel_queue [$];

    // Directed frames for the 3 x 3 geometry, in raster order.
    logic [mfilt_pkg::PIX_W-1:0] n_dummy_frame_a [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                                         8'd0, 8'd255, 8'd0, 8'd255};
    logic [mfilt_pkg::PIX_W-1:0] n_dummy_frame_b [9] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
                                                         8'd255, 8'd255, 8'd255, 8'd128};

    // Handshake bookkeeping shared by the driver, the monitor and the stimulus.
    int pixels_offered = 0;
    int pixels_taken   = 0;
    int cfg_taken      = 0;
    int medians_checked = 0;
    int error_count    = 0;
    int stalled_cycles = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // Geometry values outside 3..top behave as the nearest legal value.
    function automatic int clamp_dim(input logic [mfilt_pkg::DIM_W-1:0] raw, input int top);
        if (raw < mfilt_pkg::WIN_EDGE)
            return mfilt_pkg::WIN_EDGE;
        if (raw > top)
            return top;
        return int'(raw);
    endfunction

    // The median is the value with at most four smaller entries and at least five at or below it.
    function automatic logic [mfilt_pkg::PIX_W-1:0] median_of_nine(
        input logic [8:0][mfilt_pkg::PIX_W-1:0] v);
        int below;
        int equal;
        for (int i = 0; i < 9; i++)
        begin
            below = 0;
            equal = 0;
            for (int j = 0; j < 9; j++)
            begin
                if (v[j] < v[i])
                    below++;
                else if (v[j] == v[i])
                    equal++;
            end
            if (below <= 4 && below + equal > 4)
                return v[i];
        end
        return '0;
    endfunction

    // Moves the filter state by one accepted pixel and queues the median that it completes.
    task automatic advance_filter(input logic [mfilt_pkg::PIX_W-1:0] px);
        int                 w;
        int                 h;
        int                 c;
        int                 r;
        mfilt_pkg::column_t incoming;
        median_entry_t      entry;
        w = clamp_dim(width_reg, mfilt_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, mfilt_pkg::MAX_HEIGHT);
        c = col_cnt % mfilt_pkg::MAX_WIDTH;
        r = row_cnt;
        incoming = '{top: older_line[c], mid: newer_line[c], bot: px};
        // Only windows that lie wholly inside the image give a result.
        if (r >= 2 && c >= 2)
        begin
            entry.median = median_of_nine({win_left, win_mid, incoming});
            entry.row = mfilt_pkg::POS_W'(r - 2);
            entry.col = mfilt_pkg::POS_W'(c - 2);
            pending_medians.push_back(entry);
        end
        older_line[c] = incoming.mid;
        newer_line[c] = px;
        win_left = win_mid;
        win_mid = incoming;
        // A count at or past the last column or row (after a shrink) wraps like a normal end.
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
        end
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Pixel driver. A new item goes out only once the previous one was taken
    // (taken count caught up with offered count), so valid holds steady until accepted.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || pixels_taken == pixels_offered)
        begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                pixel <= pixel_queue.pop_front();
                in_valid <= 1'b1;
                pixels_offered++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: ready is drawn afresh at every falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge it predicts accepted pixels, tracks register
    // writes, checks results against the oldest expectation, and runs the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        median_entry_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                advance_filter(pixel);
                pixels_taken++;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mfilt_pkg::CFG_LINE_WIDTH:   width_reg = cfg_data;
                    mfilt_pkg::CFG_FRAME_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
                cfg_taken++;
            end

            if (out_valid && out_ready)
            begin
                if (pending_medians.size() == 0)
                begin
                    note_error($sformatf("unexpected result: median %0d at (%0d,%0d)",
                                         median, out_row, out_col));
                end
                else
                begin
                    want = pending_medians.pop_front();
                    medians_checked++;
                    if (median !== want.median)
                        note_error($sformatf("median mismatch (%0d,%0d): expected %0d, got %0d",
                                             want.row, want.col, want.median, median));
                    if (out_row !== want.row)
                        note_error($sformatf("out_row mismatch: expected %0d, got %0d",
                                             want.row, out_row));
                    if (out_col !== want.col)
                        note_error($sformatf("out_col mismatch: expected %0d, got %0d",
                                             want.col, out_col));
                end
            end

            // The watchdog only counts while something is still owed by either side.
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
                || !(pixel_queue.size() > 0 || in_valid || cfg_valid
                     || pending_medians.size() > 0))
            begin
                stalled_cycles = 0;
            end
            else
            begin
                stalled_cycles++;
                if (stalled_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t ns: no item moved for %0d cycles, %0d results still owed",
                             $time, WATCHDOG_LIMIT, pending_medians.size());
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                src_idle_pct = 65;
                sink_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                src_idle_pct = 0;
                sink_stall_pct = 65;
            end
            IDLE_BOTH:
            begin
                src_idle_pct = 27;
                sink_stall_pct = 27;
            end
            default:
            begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
        endcase
    endtask

    // Waits until every pixel was taken and every median came back, then lets the
    // pipeline settle, since the last pixels may have produced no result at all.
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < SETTLE_CYCLES)
        begin
            @(negedge clk);
            if (pixel_queue.size() == 0 && pixels_taken == pixels_offered
                && pending_medians.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [mfilt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mfilt_pkg::DIM_W-1:0] value);
        int taken_so_far;
        wait_idle();
        taken_so_far = cfg_taken;
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (cfg_taken == taken_so_far);
        cfg_valid <= 1'b0;
    endtask

    // Random pixels, weighted toward the extremes so that ties in the window are common.
    task automatic queue_random_pixels(input int count);
        logic [mfilt_pkg::PIX_W-1:0] px;
        repeat (count)
        begin
            case ($urandom_range(3))
                0:       px = mfilt_pkg::PIX_W'($urandom_range(3));
                1:       px = mfilt_pkg::PIX_W'($urandom_range(255, 252));
                default: px = mfilt_pkg::PIX_W'($urandom);
            endcase
            pixel_queue.push_back(px);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int                          n;
        int                          w_eff;
        int                          h_eff;
        logic [mfilt_pkg::DIM_W-1:0] w_raw;
        logic [mfilt_pkg::DIM_W-1:0] h_raw;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: geometry written below the minimum acts as 3 x 3, so every
        // nine pixels form one frame with a single window. The first frame has five
        // pixels at full scale, the second a single mid-grey value in the middle rank.
        set_idling(IDLE_NONE);
        write_reg(mfilt_pkg::CFG_LINE_WIDTH, mfilt_pkg::DIM_W'(0));
        write_reg(mfilt_pkg::CFG_FRAME_HEIGHT, mfilt_pkg::DIM_W'(1));
        foreach (n_dummy_frame_a[i])
            pixel_queue.push_back(n_dummy_frame_a[i]);
        foreach (n_dummy_frame_b[i])
            pixel_queue.push_back(n_dummy_frame_b[i]);

        // Writes to undecoded indexes must leave the geometry alone.
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, '0);

        // A wider line over four rows. The counters are at a frame start, so the
        // width may grow here.
        set_idling(IDLE_BOTH);
        write_reg(mfilt_pkg::CFG_LINE_WIDTH, mfilt_pkg::DIM_W'(WIDE_LINE));
        write_reg(mfilt_pkg::CFG_FRAME_HEIGHT, mfilt_pkg::DIM_W'(4));
        queue_random_pixels(WIDE_LINE * 4);

        // Narrowest line, taller frame: one window per row walks out_row down the frame.
        set_idling(IDLE_RECEIVER);
        write_reg(mfilt_pkg::CFG_LINE_WIDTH, mfilt_pkg::DIM_W'(3));
        write_reg(mfilt_pkg::CFG_FRAME_HEIGHT, mfilt_pkg::DIM_W'(TALL_FRAME));
        queue_random_pixels(3 * TALL_FRAME);

        // Random phases with small geometry. Each phase picks at random whether to run to a frame
        // end, so the next phase may start a wider frame, or to stop after a random count, often
        // mid-frame, so the next geometry change can land mid-row and exercise the early wrap.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_idling(idle_mode_t'(phase % 4));
            wait_idle();
            case ($urandom_range(9))
                0:       w_raw = mfilt_pkg::DIM_W'($urandom_range(2));
                1:       w_raw = mfilt_pkg::DIM_W'($urandom_range(40, 13));
                default: w_raw = mfilt_pkg::DIM_W'($urandom_range(12, 3));
            endcase
            case ($urandom_range(9))
                0:       h_raw = mfilt_pkg::DIM_W'($urandom_range(2));
                1:       h_raw = mfilt_pkg::DIM_W'($urandom_range(20, 9));
                default: h_raw = mfilt_pkg::DIM_W'($urandom_range(8, 3));
            endcase
            // Widening mid-frame would expose line store entries that were never
            // filled, so the width may only grow at the very start of a frame.
            if (clamp_dim(w_raw, mfilt_pkg::MAX_WIDTH) > clamp_dim(width_reg, mfilt_pkg::MAX_WIDTH)
                && (col_cnt != 0 || row_cnt != 0))
                w_raw = width_reg;
            write_reg(mfilt_pkg::CFG_LINE_WIDTH, w_raw);
            write_reg(mfilt_pkg::CFG_FRAME_HEIGHT, h_raw);

            if ($urandom_range(1))
            begin
                w_eff = clamp_dim(width_reg, mfilt_pkg::MAX_WIDTH);
                h_eff = clamp_dim(height_reg, mfilt_pkg::MAX_HEIGHT);
                // Pixels left in the current row (one if the count is past a shrunken
                // width), then the rows still below it; optionally one more full frame.
                n = ((col_cnt >= w_eff) ? 1 : w_eff - col_cnt)
                    + ((row_cnt + 1 >= h_eff) ? 0 : (h_eff - row_cnt - 1) * w_eff);
                if ($urandom_range(1))
                    n += w_eff * h_eff;
            end
            else
            begin
                n = $urandom_range(60, 10);
            end
            queue_random_pixels(n);
        end

        wait_idle();
        $display("Run covered %0d pixels and %0d checked medians over %0d register writes,",
                 pixels_taken, medians_checked, cfg_taken);
        $display("with clamped, wide, tall and random geometry, mid-frame changes, four stall mixes.");
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : tb

`default_nettype wire

>>> filelist.f
hdl/mfilt_pkg.sv
hdl/mfilt_line_mem.sv
hdl/mfilt_median9.sv
hdl/median_filter_3x3.sv
sim/tb.sv
